[design/assert_macros.svh]
// Assertion macros shared by the accumulator RTL.
// Depends on a clock named clk and a reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true outside reset.
`define TBWA_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Same-cycle implication.
`define TBWA_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TBWA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/tbwa_pkg.sv]
// Package for the top-4 bone weight accumulator: widths, entry layout,
// function codes and controller states. No dependencies.
package tbwa_pkg;

  localparam int VERTEX_DEPTH = 1024;
  localparam int VID_W        = $clog2(VERTEX_DEPTH);
  localparam int COUNT_W      = VID_W + 1;
  localparam int SLOTS        = 4;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int BONE_W       = 7;
  localparam int WEIGHT_W     = 16;
  localparam int SHARE_W      = WEIGHT_W + 1;
  localparam int SUM_W        = WEIGHT_W + SLOT_W;
  // numerator: weight << 16 plus half the sum
  localparam int NUM_W        = 2 * WEIGHT_W + 1;
  localparam int QUO_W        = SHARE_W;
  localparam int DIV_CNT_W    = $clog2(QUO_W);

  localparam logic [SHARE_W-1:0] SHARE_ONE = SHARE_W'(1) << WEIGHT_W;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_FIN = 1'b1;

  typedef logic [BONE_W-1:0]   bone_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [SHARE_W-1:0]  share_t;

  typedef struct packed {
    bone_t   [SLOTS-1:0] bones;
    weight_t [SLOTS-1:0] weights;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [VID_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_LOAD,
    S_START,
    S_DIV
  } state_t;

endpackage

[design/tbwa_if.sv]
// Channel interfaces of the accumulator: item, result and config write.
// Depends on tbwa_pkg.
interface tbwa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [tbwa_pkg::VID_W-1:0]  vertex_id;
  tbwa_pkg::bone_t             bone_id;
  tbwa_pkg::weight_t           weight;

  modport source(output valid, func, vertex_id, bone_id, weight, input ready);
  modport sink(input valid, func, vertex_id, bone_id, weight, output ready);
endinterface

interface tbwa_rsp_if;
  logic              valid;
  logic              ready;
  tbwa_pkg::bone_t   bone_a;
  tbwa_pkg::bone_t   bone_b;
  tbwa_pkg::bone_t   bone_c;
  tbwa_pkg::bone_t   bone_d;
  tbwa_pkg::share_t  share_a;
  tbwa_pkg::share_t  share_b;
  tbwa_pkg::share_t  share_c;
  tbwa_pkg::share_t  share_d;

  modport source(output valid, bone_a, bone_b, bone_c, bone_d,
                 share_a, share_b, share_c, share_d, input ready);
  modport sink(input valid, bone_a, bone_b, bone_c, bone_d,
               share_a, share_b, share_c, share_d, output ready);
endinterface

interface tbwa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tbwa_pkg::COUNT_W-1:0]  data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[design/tbwa_vtab.sv]
// Vertex table: one synchronous memory of slot entries with registered read,
// plus the clearing sweep after reset. Depends on tbwa_pkg.
module tbwa_vtab (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [tbwa_pkg::VID_W-1:0]  rd_addr,
  output tbwa_pkg::entry_t            rd_data,
  input  tbwa_pkg::wr_req_t           wr,
  output logic                        clearing
);

  tbwa_pkg::entry_t mem [tbwa_pkg::VERTEX_DEPTH];

  // sweep counter; top bit set once every entry is cleared
  logic [tbwa_pkg::VID_W:0] clr_cnt;

  assign clearing = !clr_cnt[tbwa_pkg::VID_W];

  // advance the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // write port: sweep has priority, no items run during it
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt[tbwa_pkg::VID_W-1:0]] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/tbwa_div.sv]
// Restoring divider, one quotient bit per cycle, for share normalization.
// Depends on tbwa_pkg.
module tbwa_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tbwa_pkg::NUM_W-1:0]    num,
  input  logic [tbwa_pkg::SUM_W-1:0]    den,
  output logic                          busy,
  output logic [tbwa_pkg::QUO_W-1:0]    quo
);

  logic [tbwa_pkg::SUM_W-1:0]     rem;
  logic [tbwa_pkg::SUM_W-1:0]     den_r;
  logic [tbwa_pkg::QUO_W-1:0]     work;
  logic [tbwa_pkg::DIV_CNT_W-1:0] cnt;
  logic [tbwa_pkg::SUM_W:0]       trial;
  logic [tbwa_pkg::SUM_W:0]       diff;
  logic                           ge;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, work[tbwa_pkg::QUO_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  // control: count the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= tbwa_pkg::DIV_CNT_W'(tbwa_pkg::QUO_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath: high numerator bits seed the remainder, quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= tbwa_pkg::SUM_W'(num[tbwa_pkg::NUM_W-1:tbwa_pkg::QUO_W]);
      work  <= num[tbwa_pkg::QUO_W-1:0];
      den_r <= den;
    end else if (busy) begin
      rem  <= ge ? diff[tbwa_pkg::SUM_W-1:0] : trial[tbwa_pkg::SUM_W-1:0];
      work <= {work[tbwa_pkg::QUO_W-2:0], ge};
    end
  end

  assign quo = work;

endmodule

[design/top4_bone_weight_accumulator.sv]
// Top level of the top-4 bone weight accumulator: controller, slot update,
// four divider lanes and the result register.
// Depends on tbwa_pkg, tbwa_if, tbwa_vtab, tbwa_div and assert_macros.svh.
//
//  channel | role   | beat
//  --------+--------+-------------------------------------------------
//  req     | sink   | func, vertex_id, bone_id, weight
//  rsp     | source | bone_a..bone_d, share_a..share_d (finalize only)
//  cfg     | sink   | data = vertex_count, always ready
//
// An add reads the table, then modifies the entry and writes it back in S_ADD.
// A finalize reads and clears the entry (S_LOAD), starts the bit-serial
// dividers on all four slots at once (S_START) and runs their 17 steps (S_DIV).
// After reset a clearing pass zeroes all 1024 entries of the vertex table; req
// stays low-ready meanwhile. The result register lets the next item in while
// a result waits; a finalize holds its result until rsp has room.
`include "assert_macros.svh"

module top4_bone_weight_accumulator (
  input logic          clk,
  input logic          rst,
  tbwa_req_if.sink     req,
  tbwa_rsp_if.source   rsp,
  tbwa_cfg_if.sink     cfg
);

  tbwa_pkg::state_t                  state;
  tbwa_pkg::state_t                  state_next;
  logic [tbwa_pkg::COUNT_W-1:0]      vertex_count;
  logic [tbwa_pkg::VID_W-1:0]        vid_r;
  tbwa_pkg::bone_t                   bone_r;
  tbwa_pkg::weight_t                 wt_r;
  tbwa_pkg::entry_t                  ent;
  logic [tbwa_pkg::SUM_W-1:0]        sum;
  logic [tbwa_pkg::SUM_W-1:0]        sum_next;

  logic                              acc;
  logic                              add_ok;
  logic                              clearing;
  tbwa_pkg::entry_t                  rd_data;
  tbwa_pkg::wr_req_t                 wr;
  tbwa_pkg::entry_t                  upd;
  logic                              found;
  logic [tbwa_pkg::SLOT_W-1:0]       empty_idx;
  logic [tbwa_pkg::SLOT_W-1:0]       lo01;
  logic [tbwa_pkg::SLOT_W-1:0]       lo23;
  logic [tbwa_pkg::SLOT_W-1:0]       min_idx;

  logic                              div_start;
  logic [tbwa_pkg::NUM_W-1:0]        div_num  [tbwa_pkg::SLOTS];
  logic [tbwa_pkg::SLOTS-1:0]        div_busy;
  logic [tbwa_pkg::QUO_W-1:0]        div_quo  [tbwa_pkg::SLOTS];

  logic                              out_valid;
  logic                              out_load;
  logic                              out_free;
  tbwa_pkg::bone_t                   out_bone  [tbwa_pkg::SLOTS];
  tbwa_pkg::share_t                  out_share [tbwa_pkg::SLOTS];

  logic                              fin_acc;
  logic                              shares_ok;

  // handshakes
  assign req.ready = (state == tbwa_pkg::S_IDLE) && !clearing;
  assign acc       = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign out_free  = !out_valid || rsp.ready;
  assign add_ok    = (req.weight != '0) &&
                     ({1'b0, req.vertex_id} < vertex_count);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg.valid) begin
      vertex_count <= cfg.data;
    end
  end

  // vertex table
  tbwa_vtab u_vtab (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (acc),
    .rd_addr  (req.vertex_id),
    .rd_data  (rd_data),
    .wr       (wr),
    .clearing (clearing)
  );

  // slot update for an add: first empty slot, else lowest-indexed minimum
  always_comb begin
    found     = 1'b0;
    empty_idx = '0;
    for (int i = tbwa_pkg::SLOTS - 1; i >= 0; i--) begin
      if (rd_data.weights[i] == '0) begin
        found     = 1'b1;
        empty_idx = tbwa_pkg::SLOT_W'(i);
      end
    end
    lo01    = (rd_data.weights[1] < rd_data.weights[0]) ? 2'd1 : 2'd0;
    lo23    = (rd_data.weights[3] < rd_data.weights[2]) ? 2'd3 : 2'd2;
    min_idx = (rd_data.weights[lo23] < rd_data.weights[lo01]) ? lo23 : lo01;
    upd     = rd_data;
    if (found) begin
      upd.bones[empty_idx]   = bone_r;
      upd.weights[empty_idx] = wt_r;
    end else if (wt_r > rd_data.weights[min_idx]) begin
      upd.bones[min_idx]   = bone_r;
      upd.weights[min_idx] = wt_r;
    end
  end

  // weight sum of the entry being finalized
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < tbwa_pkg::SLOTS; i++) begin
      sum_next = sum_next + tbwa_pkg::SUM_W'(rd_data.weights[i]);
    end
  end

  // rounded numerators: weight << 16 plus half the sum
  always_comb begin
    for (int i = 0; i < tbwa_pkg::SLOTS; i++) begin
      div_num[i] = tbwa_pkg::NUM_W'({ent.weights[i], {tbwa_pkg::WEIGHT_W{1'b0}}}) +
                   tbwa_pkg::NUM_W'(sum[tbwa_pkg::SUM_W-1:1]);
    end
  end

  // divider lanes, one per slot
  for (genvar g = 0; g < tbwa_pkg::SLOTS; g++) begin : g_lane
    tbwa_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (div_num[g]),
      .den   (sum),
      .busy  (div_busy[g]),
      .quo   (div_quo[g])
    );
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbwa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next = state;
    wr         = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      tbwa_pkg::S_IDLE: begin
        if (acc) begin
          if (req.func == tbwa_pkg::FUNC_FIN) begin
            state_next = tbwa_pkg::S_LOAD;
          end else if (add_ok) begin
            state_next = tbwa_pkg::S_ADD;
          end
        end
      end
      tbwa_pkg::S_ADD: begin
        wr.en      = 1'b1;
        wr.addr    = vid_r;
        wr.data    = upd;
        state_next = tbwa_pkg::S_IDLE;
      end
      tbwa_pkg::S_LOAD: begin
        // clear the entry while its contents move to ent
        wr.en      = 1'b1;
        wr.addr    = vid_r;
        state_next = tbwa_pkg::S_START;
      end
      tbwa_pkg::S_START: begin
        div_start  = 1'b1;
        state_next = tbwa_pkg::S_DIV;
      end
      tbwa_pkg::S_DIV: begin
        if (!(|div_busy) && out_free) begin
          out_load   = 1'b1;
          state_next = tbwa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tbwa_pkg::S_IDLE;
      end
    endcase
  end

  // capture item fields and the finalized entry
  always_ff @(posedge clk) begin
    if (acc) begin
      vid_r  <= req.vertex_id;
      bone_r <= req.bone_id;
      wt_r   <= req.weight;
    end
    if (state == tbwa_pkg::S_LOAD) begin
      ent <= rd_data;
      sum <= sum_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // zero sum gives zero shares; zero share drops the bone id
  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < tbwa_pkg::SLOTS; i++) begin
        if (sum != '0 && div_quo[i] != '0) begin
          out_share[i] <= div_quo[i];
          out_bone[i]  <= ent.bones[i];
        end else begin
          out_share[i] <= '0;
          out_bone[i]  <= '0;
        end
      end
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.bone_a  = out_bone[0];
  assign rsp.bone_b  = out_bone[1];
  assign rsp.bone_c  = out_bone[2];
  assign rsp.bone_d  = out_bone[3];
  assign rsp.share_a = out_share[0];
  assign rsp.share_b = out_share[1];
  assign rsp.share_c = out_share[2];
  assign rsp.share_d = out_share[3];

  // terms for the checks
  assign fin_acc   = acc && (req.func == tbwa_pkg::FUNC_FIN);
  assign shares_ok = (rsp.share_a <= tbwa_pkg::SHARE_ONE) &&
                     (rsp.share_b <= tbwa_pkg::SHARE_ONE) &&
                     (rsp.share_c <= tbwa_pkg::SHARE_ONE) &&
                     (rsp.share_d <= tbwa_pkg::SHARE_ONE);

  // checks
  `TBWA_ASSERT_NEVER(a_no_item_in_clear, req.ready && clearing, "item taken during clear pass")
  `TBWA_ASSERT_NEXT(a_fin_reads, fin_acc, state == tbwa_pkg::S_LOAD, "finalize skipped read")
  `TBWA_ASSERT_IMPLIES(a_div_in_state, |div_busy, state == tbwa_pkg::S_DIV, "stray divider run")
  `TBWA_ASSERT_IMPLIES(a_share_range, rsp.valid, shares_ok, "share above one")

endmodule
